>>> rtl/slr_pkg.sv
// ---------------------------------------------------------------------------
// slr_pkg - shared types and constants of the stereo linear resampler
// Rates, widths, the fixed-point reciprocal used for rounding division and
// the sequencer state type.
// ---------------------------------------------------------------------------
package slr_pkg;

  // Sample and rate widths
  localparam int SAMPLE_BITS = 16;
  localparam int RATE_W      = 17;
  localparam int PHASE_W     = 17;
  localparam int CNT_W       = 3;

  // Shared multiplier operand and product widths
  localparam int MUL_W  = 30;
  localparam int PROD_W = 2 * MUL_W;

  // Output rate and source rate bounds
  localparam logic [PHASE_W-1:0] OUTPUT_RATE = 17'd44100;
  localparam logic [RATE_W-1:0]  RATE_MIN    = 17'd8000;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 17'd65536;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 17'd32768;

  // Results kept per input frame
  localparam logic [CNT_W-1:0] MAX_RESULTS = 3'd6;

  // Rounding offset: half of the output rate
  localparam logic [31:0] HALF_RATE = 32'd22050;

  // Quotient by OUTPUT_RATE: drop two bits, then multiply by the rounded-up
  // reciprocal of a quarter of the rate. Exact for every magnitude here.
  localparam logic [63:0] RATE_QUARTER = 64'd11025;
  localparam int          RECIP_SHIFT  = 42;
  localparam logic [63:0] RECIP_FULL   =
    ((64'd1 << RECIP_SHIFT) + RATE_QUARTER - 64'd1) / RATE_QUARTER;
  localparam logic [MUL_W-2:0] RECIP = RECIP_FULL[MUL_W-2:0];

  // Saturation limits
  localparam logic [SAMPLE_BITS-1:0] SAT_MAX = 16'h7FFF;
  localparam logic [SAMPLE_BITS-1:0] SAT_MIN = 16'h8000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL_A,
    ST_MUL_D,
    ST_SUM,
    ST_MUL_R,
    ST_SAT,
    ST_EMIT
  } slr_state_t;

endpackage

>>> rtl/slr_in_if.sv
// ---------------------------------------------------------------------------
// slr_in_if - source frame channel
// Valid/ready channel carrying one signed stereo source frame per request.
// ---------------------------------------------------------------------------
interface slr_in_if;
  import slr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] left_sample;
  logic signed [SAMPLE_BITS-1:0] right_sample;

  modport source (output valid, output left_sample, output right_sample, input ready);
  modport sink   (input valid, input left_sample, input right_sample, output ready);

endinterface

>>> rtl/slr_out_if.sv
// ---------------------------------------------------------------------------
// slr_out_if - interpolated frame channel
// Valid/ready channel carrying one output frame and its end-of-run flag.
// ---------------------------------------------------------------------------
interface slr_out_if;
  import slr_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] out_left;
  logic signed [SAMPLE_BITS-1:0] out_right;
  logic                          run_last;

  modport source (output valid, output out_left, output out_right, output run_last,
                  input ready);
  modport sink   (input valid, input out_left, input out_right, input run_last,
                  output ready);

endinterface

>>> rtl/stereo_linear_resampler.sv
// ---------------------------------------------------------------------------
// stereo_linear_resampler - stereo linear-interpolation rate converter
// Converts a signed 16-bit stereo stream from a programmable source rate to
// 44100 Hz by linear interpolation between successive source frames.
// ---------------------------------------------------------------------------
// in_ch carries one source frame per request; out_ch returns zero or more
// interpolated frames per source frame, the last of each run flagged by
// run_last. cfg_wr_en/cfg_wr_data write the source rate (clamped to
// 8000..65536 in use); write it only while the block is idle.
// The first frame after reset only primes the history and gives no output.
// Each output frame takes one phase check, five steps per channel through
// the single shared multiplier (weight, slope, magnitude, reciprocal,
// saturate) and one load into the output register. A source frame keeps
// in_ch.ready low through its n outputs (at most 6) and one phase check per
// dropped output, until a final phase check. The first output is valid once
// the request has passed the phase check, both channels' steps and the load.
// Reset invalidates the history, clears the phase and the output request
// and restores the source rate to 32768. A stalled receiver holds the
// output register and the sequencer waits in its load step; the next
// source frame is still taken while the last result of a run waits.
// ---------------------------------------------------------------------------
module stereo_linear_resampler
  import slr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  slr_in_if.sink            in_ch,
  slr_out_if.source         out_ch,
  input  logic              cfg_wr_en,
  input  logic [RATE_W-1:0] cfg_wr_data
);

  // Control registers
  slr_state_t         state_r, state_nxt;
  logic [RATE_W-1:0]  rate_cfg_r, rate_cfg_nxt;
  logic               have_prev_r, have_prev_nxt;
  logic [PHASE_W-1:0] phase_r, phase_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ch_r, ch_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [SAMPLE_BITS-1:0] prev_left_r, prev_left_nxt;
  logic signed [SAMPLE_BITS-1:0] prev_right_r, prev_right_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_left_r, cur_left_nxt;
  logic signed [SAMPLE_BITS-1:0] cur_right_r, cur_right_nxt;
  logic signed [31:0]            acc_r, acc_nxt;
  logic                          neg_r, neg_nxt;
  logic [MUL_W-2:0]              yq_r, yq_nxt;
  logic [SAMPLE_BITS-1:0]        res_left_r, res_left_nxt;
  logic [SAMPLE_BITS-1:0]        res_right_r, res_right_nxt;
  logic [SAMPLE_BITS-1:0]        out_left_r, out_left_nxt;
  logic [SAMPLE_BITS-1:0]        out_right_r, out_right_nxt;
  logic                          out_last_r, out_last_nxt;

  // Datapath signals
  logic [RATE_W-1:0]             rate_eff;
  logic [PHASE_W-1:0]            phase_step;
  logic                          step_done;
  logic signed [SAMPLE_BITS-1:0] samp_a;
  logic signed [SAMPLE_BITS-1:0] samp_b;
  logic signed [SAMPLE_BITS:0]   slope;
  logic signed [MUL_W-1:0]       op_a;
  logic signed [MUL_W-1:0]       op_b;
  logic signed [PROD_W-1:0]      prod_r;
  logic signed [31:0]            num;
  logic [31:0]                   mag;
  logic [31:0]                   mag_rnd;
  logic [SAMPLE_BITS:0]          quot;
  logic [SAMPLE_BITS:0]          quot_neg;
  logic [SAMPLE_BITS-1:0]        sat_val;

  // Clamp the programmed rate into its working range
  always_comb begin
    if (rate_cfg_r < RATE_MIN) begin
      rate_eff = RATE_MIN;
    end else if (rate_cfg_r > RATE_MAX) begin
      rate_eff = RATE_MAX;
    end else begin
      rate_eff = rate_cfg_r;
    end
  end

  // Advance phase by one output step; phase stays below OUTPUT_RATE + RATE_MAX
  assign phase_step = phase_r + rate_eff;
  assign step_done  = (phase_step >= OUTPUT_RATE);

  // Select the channel under work
  assign samp_a = ch_r ? prev_right_r : prev_left_r;
  assign samp_b = ch_r ? cur_right_r : cur_left_r;
  assign slope  = {samp_b[SAMPLE_BITS-1], samp_b} - {samp_a[SAMPLE_BITS-1], samp_a};

  // Feed the shared multiplier for the current step
  always_comb begin
    case (state_r)
      ST_MUL_A: begin
        op_a = {{(MUL_W-SAMPLE_BITS){samp_a[SAMPLE_BITS-1]}}, samp_a};
        op_b = {{(MUL_W-PHASE_W){1'b0}}, OUTPUT_RATE};
      end
      ST_MUL_D: begin
        op_a = {{(MUL_W-SAMPLE_BITS-1){slope[SAMPLE_BITS]}}, slope};
        op_b = {{(MUL_W-PHASE_W){1'b0}}, phase_r};
      end
      ST_MUL_R: begin
        op_a = {1'b0, yq_r};
        op_b = {1'b0, RECIP};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  slr_mul u_mul (
    .clk    (clk),
    .op_a   (op_a),
    .op_b   (op_b),
    .prod_r (prod_r)
  );

  // Magnitude of the weighted sum plus half a divisor for rounding
  assign num     = acc_r + $signed(prod_r[31:0]);
  assign mag     = num[31] ? (32'd0 - num) : num;
  assign mag_rnd = mag + HALF_RATE;

  // Restore the sign and saturate the rounded quotient
  assign quot     = prod_r[RECIP_SHIFT+SAMPLE_BITS:RECIP_SHIFT];
  assign quot_neg = 17'd0 - quot;
  always_comb begin
    if (neg_r) begin
      sat_val = (quot > {1'b0, SAT_MIN}) ? SAT_MIN : quot_neg[SAMPLE_BITS-1:0];
    end else begin
      sat_val = (quot > {1'b0, SAT_MAX}) ? SAT_MAX : quot[SAMPLE_BITS-1:0];
    end
  end

  // Sequencer: next state and register updates
  always_comb begin
    state_nxt      = state_r;
    rate_cfg_nxt   = rate_cfg_r;
    have_prev_nxt  = have_prev_r;
    phase_nxt      = phase_r;
    cnt_nxt        = cnt_r;
    ch_nxt         = ch_r;
    out_valid_nxt  = out_valid_r;
    prev_left_nxt  = prev_left_r;
    prev_right_nxt = prev_right_r;
    cur_left_nxt   = cur_left_r;
    cur_right_nxt  = cur_right_r;
    acc_nxt        = acc_r;
    neg_nxt        = neg_r;
    yq_nxt         = yq_r;
    res_left_nxt   = res_left_r;
    res_right_nxt  = res_right_r;
    out_left_nxt   = out_left_r;
    out_right_nxt  = out_right_r;
    out_last_nxt   = out_last_r;
    in_ch.ready    = 1'b0;

    // Take a rate write
    if (cfg_wr_en) begin
      rate_cfg_nxt = cfg_wr_data;
    end

    // Drop the output request once taken
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          cur_left_nxt  = in_ch.left_sample;
          cur_right_nxt = in_ch.right_sample;
          if (!have_prev_r) begin
            prev_left_nxt  = in_ch.left_sample;
            prev_right_nxt = in_ch.right_sample;
            have_prev_nxt  = 1'b1;
          end else begin
            cnt_nxt   = '0;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (phase_r >= OUTPUT_RATE) begin
          phase_nxt      = phase_r - OUTPUT_RATE;
          prev_left_nxt  = cur_left_r;
          prev_right_nxt = cur_right_r;
          state_nxt      = ST_IDLE;
        end else if (cnt_r == MAX_RESULTS) begin
          // Run full: advance phase without output
          phase_nxt = phase_step;
        end else begin
          ch_nxt    = 1'b0;
          state_nxt = ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        state_nxt = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_nxt   = $signed(prod_r[31:0]);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        neg_nxt   = num[31];
        yq_nxt    = mag_rnd[MUL_W:2];
        state_nxt = ST_MUL_R;
      end
      ST_MUL_R: begin
        state_nxt = ST_SAT;
      end
      ST_SAT: begin
        if (!ch_r) begin
          res_left_nxt = sat_val;
          ch_nxt       = 1'b1;
          state_nxt    = ST_MUL_A;
        end else begin
          res_right_nxt = sat_val;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        // Hold until the output register is free
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_left_nxt  = res_left_r;
          out_right_nxt = res_right_r;
          out_last_nxt  = step_done || (cnt_r == MAX_RESULTS - 3'd1);
          phase_nxt     = phase_step;
          cnt_nxt       = cnt_r + 3'd1;
          state_nxt     = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      rate_cfg_r  <= RATE_RESET;
      have_prev_r <= 1'b0;
      phase_r     <= '0;
      cnt_r       <= '0;
      ch_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rate_cfg_r  <= rate_cfg_nxt;
      have_prev_r <= have_prev_nxt;
      phase_r     <= phase_nxt;
      cnt_r       <= cnt_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    prev_left_r  <= prev_left_nxt;
    prev_right_r <= prev_right_nxt;
    cur_left_r   <= cur_left_nxt;
    cur_right_r  <= cur_right_nxt;
    acc_r        <= acc_nxt;
    neg_r        <= neg_nxt;
    yq_r         <= yq_nxt;
    res_left_r   <= res_left_nxt;
    res_right_r  <= res_right_nxt;
    out_left_r   <= out_left_nxt;
    out_right_r  <= out_right_nxt;
    out_last_r   <= out_last_nxt;
  end

  // Drive the output channel
  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_left  = out_left_r;
  assign out_ch.out_right = out_right_r;
  assign out_ch.run_last  = out_last_r;

endmodule

>>> rtl/slr_mul.sv
// ---------------------------------------------------------------------------
// slr_mul - shared signed multiplier
// One registered signed multiply, reused by the sequencer for the weight,
// slope and reciprocal products.
// ---------------------------------------------------------------------------
module slr_mul
  import slr_pkg::*;
(
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  op_a,
  input  logic signed [MUL_W-1:0]  op_b,
  output logic signed [PROD_W-1:0] prod_r
);

  // Register the product
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

endmodule

>>> rtl/slr_checker.sv
// ---------------------------------------------------------------------------
// slr_checker - port-level checks for the stereo linear resampler
// Watches the channel ports of the top level over time; bound below.
// ---------------------------------------------------------------------------
module slr_checker
  import slr_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [SAMPLE_BITS-1:0] out_left,
  input logic [SAMPLE_BITS-1:0] out_right,
  input logic                   run_last
);

  // Hold a stalled output request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output request dropped while stalled");

  // Hold a stalled output payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_left) && $stable(out_right) && $stable(run_last))
    else $error("output payload changed while stalled");

  // Leave reset with no output pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid straight after reset");

  // New output only appears while the sequencer is busy, never from idle
  a_rise_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready) && !$past(in_valid && in_ready))
    else $error("output raised without a frame in work");

endmodule

bind stereo_linear_resampler slr_checker u_slr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_left  (out_ch.out_left),
  .out_right (out_ch.out_right),
  .run_last  (out_ch.run_last)
);

>>> tb/tb_stereo_linear_resampler.sv
// ---------------------------------------------------------------------------
// tb_stereo_linear_resampler - self-checking bench for the stereo resampler
// Feeds signed stereo source frames through the request channel at several
// source rates. A bit-exact integer interpolator predicts every output frame
// and its end-of-run flag. Each returned frame is checked in order against
// that prediction while both channels idle and stall at random.
// ---------------------------------------------------------------------------
module tb_stereo_linear_resampler;
  import slr_pkg::*;

  // Run bounds: hard cycle limit, and quiet cycles before a rate change or the end
  localparam int LIMIT_CYCLES  = 400000;
  localparam int SETTLE_CYCLES = 100;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_FRAMES  = 25;

  // Interpolation arithmetic in plain signed integers
  localparam longint RATE_DEN  = longint'(OUTPUT_RATE);
  localparam longint SAMPLE_HI = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SAMPLE_LO = -(longint'(1) <<< (SAMPLE_BITS - 1));

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    logic                          last;
  } stereo_frame_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_wr_en;
  logic [RATE_W-1:0] cfg_wr_data;

  slr_in_if  in_ch ();
  slr_out_if out_ch ();

  stereo_linear_resampler dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // Predicted converter state, mirrored from the accepted requests
  logic [RATE_W-1:0]             rate_setting;
  logic signed [SAMPLE_BITS-1:0] held_left;
  logic signed [SAMPLE_BITS-1:0] held_right;
  logic                          history_valid;
  int unsigned                   phase_acc;

  stereo_frame_t expected_frames[$];

  // Pacing knobs for both sides of the block
  int gap_max    = 0;
  int burst_left = 1;
  int stall_pct  = 0;
  int stall_max  = 0;
  int stall_left = 0;

  int error_count   = 0;
  int frames_sent   = 0;
  int results_seen  = 0;
  int rate_writes   = 0;
  int cycle_count   = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("stereo_linear_resampler: mismatch");
      $finish;
    end
  end

  // Receiver: random stalls of random length, none while stall_pct is zero
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (int'($urandom_range(0, 99)) < stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left   <= int'($urandom_range(0, stall_max));
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Compare each returned frame with the oldest prediction
  always @(posedge clk) begin : check_results
    stereo_frame_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (expected_frames.size() == 0) begin
        $error("unexpected output frame: out_left %0d out_right %0d run_last %0b",
               out_ch.out_left, out_ch.out_right, out_ch.run_last);
        error_count++;
      end else begin
        want = expected_frames.pop_front();
        if (out_ch.out_left !== want.left) begin
          $error("out_left: expected %0d, got %0d", want.left, out_ch.out_left);
          error_count++;
        end
        if (out_ch.out_right !== want.right) begin
          $error("out_right: expected %0d, got %0d", want.right, out_ch.out_right);
          error_count++;
        end
        if (out_ch.run_last !== want.last) begin
          $error("run_last: expected %0b, got %0b", want.last, out_ch.run_last);
          error_count++;
        end
      end
    end
  end

  // Weighted blend of two samples at the given phase, rounded half away from zero
  function automatic logic signed [SAMPLE_BITS-1:0] blend_sample(
    input logic signed [SAMPLE_BITS-1:0] a,
    input logic signed [SAMPLE_BITS-1:0] b,
    input int unsigned                   ph
  );
    longint num;
    longint mag;
    longint q;
    num = longint'(a) * RATE_DEN + (longint'(b) - longint'(a)) * longint'(ph);
    mag = (num < 0) ? -num : num;
    q   = (2 * mag + RATE_DEN) / (2 * RATE_DEN);
    q   = (num < 0) ? -q : q;
    if (q > SAMPLE_HI) q = SAMPLE_HI;
    if (q < SAMPLE_LO) q = SAMPLE_LO;
    return q[SAMPLE_BITS-1:0];
  endfunction

  // Work out the output frames that one accepted source frame produces
  function automatic void resample_frame(input logic signed [SAMPLE_BITS-1:0] left,
                                         input logic signed [SAMPLE_BITS-1:0] right);
    int unsigned   rate;
    int            n;
    stereo_frame_t run[$];
    stereo_frame_t f;
    rate = 32'(rate_setting);
    n    = 0;
    if (rate < RATE_MIN) rate = 32'(RATE_MIN);
    if (rate > RATE_MAX) rate = 32'(RATE_MAX);
    // First frame only primes the history
    if (!history_valid) begin
      held_left     = left;
      held_right    = right;
      history_valid = 1'b1;
      return;
    end
    // Emit while the phase lies before this frame; drop outputs past the limit
    while (phase_acc < OUTPUT_RATE) begin
      if (n < int'(MAX_RESULTS)) begin
        f.left  = blend_sample(held_left, left, phase_acc);
        f.right = blend_sample(held_right, right, phase_acc);
        f.last  = 1'b0;
        run.push_back(f);
        n++;
      end
      phase_acc += rate;
    end
    phase_acc -= 32'(OUTPUT_RATE);
    if (n > 0) run[n-1].last = 1'b1;
    foreach (run[i]) expected_frames.push_back(run[i]);
    held_left  = left;
    held_right = right;
  endfunction

  // Random sample: extremes, small steps from the last value, or anything
  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
    input logic signed [SAMPLE_BITS-1:0] last
  );
    int v;
    case ($urandom_range(0, 7))
      0:       v = int'(SAMPLE_LO);
      1:       v = int'(SAMPLE_HI);
      2, 3:    v = int'(last) + int'($urandom_range(0, 2000)) - 1000;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > SAMPLE_HI) v = int'(SAMPLE_HI);
    if (v < SAMPLE_LO) v = int'(SAMPLE_LO);
    return v[SAMPLE_BITS-1:0];
  endfunction

  // Present one request, hold it until taken, then predict; pause between bursts
  task automatic send_frame(input logic signed [SAMPLE_BITS-1:0] left,
                            input logic signed [SAMPLE_BITS-1:0] right);
    in_ch.valid        <= 1'b1;
    in_ch.left_sample  <= left;
    in_ch.right_sample <= right;
    do @(posedge clk); while (!in_ch.ready);
    resample_frame(left, right);
    frames_sent++;
    if (gap_max > 0) begin
      burst_left--;
      if (burst_left <= 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, gap_max)) @(posedge clk);
        burst_left = $urandom_range(1, 8);
      end
    end
  endtask

  // Stop sending and wait until every predicted frame has come back
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Change the source rate with the block idle
  task automatic write_source_rate(input logic [RATE_W-1:0] rate);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= rate;
    @(posedge clk);
    cfg_wr_en    <= 1'b0;
    rate_setting  = rate;
    rate_writes++;
  endtask

  // Reset rate, priming frame first, then full-scale swings
  task automatic test_reset_rate();
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh0000, 16'sh0000);
    send_frame(-16'sd1, 16'sd1);
    send_frame(16'sd16384, -16'sd16384);
  endtask

  // Slowest source: six outputs for some frames
  task automatic test_slowest_rate();
    write_source_rate(RATE_MIN);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sd1, -16'sd1);
    send_frame(16'sh8000, 16'sh7FFF);
  endtask

  // Out-of-range rates are clamped in use: zero and all ones
  task automatic test_rate_clamp();
    write_source_rate('0);
    send_frame(16'sh7FFF, 16'sh0000);
    send_frame(16'sh0000, 16'sh8000);
    write_source_rate('1);
    send_frame(16'sh8000, 16'sh7FFF);
    send_frame(16'sh7FFF, 16'sh8000);
    send_frame(16'sh5555, -16'sh5556);
    send_frame(-16'sh2AAB, 16'sh2AAA);
  endtask

  // Fastest source: some frames give no output at all
  task automatic test_fastest_rate();
    write_source_rate(RATE_MAX);
    send_frame(16'sh8000, 16'sh8000);
    send_frame(16'sh7FFF, 16'sh7FFF);
    send_frame(-16'sd1, -16'sd1);
    send_frame(16'sh0000, 16'sh7FFF);
  endtask

  // Random rates and samples under random pacing, in phases
  task automatic test_random_stream();
    logic [RATE_W-1:0]             rate;
    logic signed [SAMPLE_BITS-1:0] left;
    logic signed [SAMPLE_BITS-1:0] right;
    left  = '0;
    right = '0;
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case ($urandom_range(0, 5))
        0:       rate = RATE_MIN;
        1:       rate = RATE_MAX;
        2:       rate = RATE_W'($urandom_range(0, int'(RATE_MIN) - 1));
        3:       rate = RATE_W'($urandom_range(int'(RATE_MAX) + 1, (1 << RATE_W) - 1));
        default: rate = RATE_W'($urandom_range(int'(RATE_MIN), int'(RATE_MAX)));
      endcase
      write_source_rate(rate);
      // Pacing for this phase: none, light or heavy
      case (p % 3)
        0: begin
          gap_max   = 0;
          stall_pct = 0;
          stall_max = 0;
        end
        1: begin
          gap_max   = 3;
          stall_pct = 15;
          stall_max = 4;
        end
        default: begin
          gap_max   = 8;
          stall_pct = 30;
          stall_max = 24;
        end
      endcase
      burst_left = $urandom_range(1, 8);
      for (int i = 0; i < PHASE_FRAMES; i++) begin
        left  = pick_sample(left);
        right = pick_sample(right);
        send_frame(left, right);
        // Hold off mid-phase until the output side has drained
        if (p % 2 == 1 && i == PHASE_FRAMES / 2) wait_idle();
      end
    end
    gap_max   = 0;
    stall_pct = 0;
  endtask

  initial begin
    in_ch.valid        <= 1'b0;
    in_ch.left_sample  <= '0;
    in_ch.right_sample <= '0;
    cfg_wr_en          <= 1'b0;
    cfg_wr_data        <= '0;
    rate_setting        = RATE_RESET;
    held_left           = '0;
    held_right          = '0;
    history_valid       = 1'b0;
    phase_acc           = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_rate();
    test_slowest_rate();
    test_rate_clamp();
    test_fastest_rate();
    test_random_stream();

    wait_idle();
    $display("covered %0d source frames over %0d rate writes, %0d output frames checked",
             frames_sent, rate_writes, results_seen);
    if (error_count == 0) begin
      $display("stereo_linear_resampler: match");
    end else begin
      $display("stereo_linear_resampler: mismatch");
    end
    $finish;
  end

endmodule
